>>> hdl/pold_pkg.sv
// ----------------------------------------------------------------------------
// pold_pkg
// Shared types and constants for the prime odd leading digit filter.
// ----------------------------------------------------------------------------
package pold_pkg;

  localparam int ValueW = 32;
  localparam int MagW   = ValueW - 1;
  localparam int DivW   = 16;
  localparam int SqW    = ValueW + 1;
  localparam int CntW   = $clog2(MagW);

  localparam logic [CntW-1:0] LastStep   = CntW'(MagW - 1);
  localparam logic [DivW-1:0] FirstOdd   = DivW'(3);
  localparam logic [SqW-1:0]  FirstOddSq = SqW'(9);
  localparam logic [DivW-1:0] Radix      = DivW'(10);
  localparam logic [MagW-1:0] SmallestPrime = MagW'(2);
  localparam logic [MagW-1:0] FirstComposite = MagW'(4);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCREEN,
    ST_TRIAL,
    ST_TRIAL_DIV,
    ST_LEAD,
    ST_LEAD_DIV,
    ST_FINISH
  } pold_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> hdl/pold_in_if.sv
// ----------------------------------------------------------------------------
// pold_in_if
// Input channel: one value to test and its last-of-list mark.
// ----------------------------------------------------------------------------
interface pold_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink (input valid, input value, input last_in, output ready);
endinterface

>>> hdl/pold_out_if.sv
// ----------------------------------------------------------------------------
// pold_out_if
// Result channel: tested value, flags and last-of-list mark.
// ----------------------------------------------------------------------------
interface pold_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_out;
  logic               is_prime;
  logic               selected;
  logic               last_out;

  modport source (output valid, output value_out, output is_prime, output selected,
                  output last_out, input ready);
  modport sink (input valid, input value_out, input is_prime, input selected,
                input last_out, output ready);
endinterface

>>> hdl/prime_odd_leading_digit_filter_unit.sv
// ----------------------------------------------------------------------------
// prime_odd_leading_digit_filter_unit
// Trial-division primality test with odd leading decimal digit selection.
//
//   channel  dir  fields
//   item     in   value[31:0] signed, last_in
//   result   out  value_out[31:0] signed, is_prime, selected, last_out
//
// One transaction at a time; item.ready is high only while idle.
// Each trial divisor costs one pass through the shared 31-step divider;
// a prime n is divided by every odd divisor from 3 whose square is at most n,
// plus up to 9 divisions by ten for the leading digit.
// Synchronous active-high reset clears the sequencer and result valid.
// A stalled result holds; the next item may be accepted meanwhile.
// ----------------------------------------------------------------------------
module prime_odd_leading_digit_filter_unit
  import pold_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pold_in_if.sink    item,
  pold_out_if.source result
);

  pold_state_t state;
  pold_state_t state_next;

  logic signed [ValueW-1:0] val;
  logic                     last;
  logic                     neg;
  logic [MagW-1:0]          n;
  logic [MagW-1:0]          m;
  logic [DivW-1:0]          d;
  logic [SqW-1:0]           sq;
  logic                     prime;
  logic                     sel;

  logic                     res_valid;
  logic signed [ValueW-1:0] res_value;
  logic                     res_prime;
  logic                     res_sel;
  logic                     res_last;

  logic                     accept;
  logic                     sq_over;
  logic                     m_small;
  logic                     div_start;
  logic                     out_load;
  logic [MagW-1:0]          div_dividend;
  logic [DivW-1:0]          div_divisor;
  div_status_t              div_st;
  logic [MagW-1:0]          div_quot;
  logic [DivW-1:0]          div_rem;

  assign accept  = item.valid && item.ready;
  assign sq_over = sq > {2'b00, n};
  assign m_small = m < MagW'(Radix);

  pold_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_st),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign div_dividend = (state == ST_LEAD) ? m : n;
  assign div_divisor  = (state == ST_LEAD) ? Radix : d;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (item.valid) state_next = ST_SCREEN;
      ST_SCREEN: begin
        if (neg || n < SmallestPrime) state_next = ST_FINISH;
        else if (n < FirstComposite)  state_next = ST_LEAD;
        else if (!n[0])               state_next = ST_FINISH;
        else                          state_next = ST_TRIAL;
      end
      ST_TRIAL:     state_next = sq_over ? ST_LEAD : ST_TRIAL_DIV;
      ST_TRIAL_DIV: begin
        if (div_st.done) state_next = (div_rem == '0) ? ST_FINISH : ST_TRIAL;
      end
      ST_LEAD:      state_next = m_small ? ST_FINISH : ST_LEAD_DIV;
      ST_LEAD_DIV:  if (div_st.done) state_next = ST_LEAD;
      ST_FINISH:    if (!res_valid || result.ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item.ready = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE:   item.ready = 1'b1;
      ST_TRIAL:  div_start  = !sq_over;
      ST_LEAD:   div_start  = !m_small;
      ST_FINISH: out_load   = !res_valid || result.ready;
      default: begin
        item.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          val  <= item.value;
          last <= item.last_in;
          neg  <= item.value[ValueW-1];
          n    <= item.value[MagW-1:0];
        end
      end
      ST_SCREEN: begin
        prime <= !neg && (n >= SmallestPrime) && ((n < FirstComposite) || n[0]);
        sel   <= 1'b0;
        d     <= FirstOdd;
        sq    <= FirstOddSq;
        m     <= n;
      end
      ST_TRIAL_DIV: begin
        if (div_st.done) begin
          if (div_rem == '0) begin
            prime <= 1'b0;
          end else begin
            d  <= d + DivW'(2);
            sq <= sq + SqW'({d, 2'b00}) + SqW'(4);
          end
        end
      end
      ST_LEAD:     if (m_small) sel <= m[0];
      ST_LEAD_DIV: if (div_st.done) m <= div_quot;
      default: begin
        m <= m;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_value <= val;
      res_prime <= prime;
      res_sel   <= sel;
      res_last  <= last;
    end
  end

  assign result.valid     = res_valid;
  assign result.value_out = res_value;
  assign result.is_prime  = res_prime;
  assign result.selected  = res_sel;
  assign result.last_out  = res_last;

`ifndef NO_ASSERTIONS
  a_start_idle_div : assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  a_odd_divisor : assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRIAL) |-> d[0])
    else $error("even trial divisor");

  a_sel_prime : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_sel) |-> res_prime)
    else $error("selected result is not prime");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    accept |=> !item.ready)
    else $error("ready right after accept");
`endif

endmodule

>>> hdl/pold_div.sv
// ----------------------------------------------------------------------------
// pold_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pold_div
  import pold_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [MagW-1:0] dividend,
  input  logic [DivW-1:0] divisor,
  output div_status_t     status,
  output logic [MagW-1:0] quot,
  output logic [DivW-1:0] rem
);

  logic            busy;
  logic            done;
  logic [CntW-1:0] cnt;
  logic [MagW-1:0] dvd;
  logic [DivW-1:0] dvs;
  logic [DivW-1:0] part;
  logic [DivW:0]   trial;
  logic [DivW+1:0] diff;
  logic            ge;

  assign trial = {part, dvd[MagW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};
  assign ge    = !diff[DivW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= LastStep;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      part <= '0;
    end else if (busy) begin
      part <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
      dvd  <= {dvd[MagW-2:0], ge};
    end
  end

  assign status = '{busy: busy, done: done};
  assign quot   = dvd;
  assign rem    = part;

endmodule
